// ===== src/sfn_pkg.sv =====
// ----------------------------------------------------------------------------
// sfn_pkg: shared types and constants for the Shift-JIS file name checker
// Holds the byte class record and the byte range tests used by the stages.
// ----------------------------------------------------------------------------
package sfn_pkg;

  // Width of the saturating length counter (holds up to 31).
  localparam int CountW = 5;

  // Default maximum name length in bytes.
  localparam int MaxNameLenDefault = 20;

  // Byte codes with a fixed meaning.
  localparam logic [7:0] ByteEnd   = 8'h00;
  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [7:0] ByteDel   = 8'h7F;

  // Classification of one name byte.
  typedef struct packed {
    logic is_end;     // terminator
    logic single_ok;  // legal single-byte character
    logic lead;       // Shift-JIS lead byte
    logic trail;      // legal Shift-JIS trail byte
  } byte_class_t;

  // Printable ASCII other than '/', or half-width katakana.
  function automatic logic single_ok_f(input logic [7:0] b);
    logic in_range;
    in_range = (b inside {[8'h20:8'h7E], [8'hA1:8'hDF]});
    return in_range && (b != ByteSlash);
  endfunction

  // Shift-JIS lead byte range, limited here to 0x81-0x98.
  function automatic logic lead_f(input logic [7:0] b);
    return (b inside {[8'h81:8'h98]});
  endfunction

  // Shift-JIS trail byte range, with DEL excluded.
  function automatic logic trail_f(input logic [7:0] b);
    logic in_range;
    in_range = (b inside {[8'h40:8'hFC]});
    return in_range && (b != ByteDel);
  endfunction

endpackage

// ===== src/sfn_classify.sv =====
// ----------------------------------------------------------------------------
// sfn_classify: byte classifier
// Sorts a registered name byte into terminator, single, lead and trail classes.
// ----------------------------------------------------------------------------
module sfn_classify (
  input  logic [7:0]          name_byte,
  output sfn_pkg::byte_class_t cls
);
  import sfn_pkg::*;

  // Pure range decode of the byte.
  always_comb begin
    cls.is_end    = (name_byte == ByteEnd);
    cls.single_ok = single_ok_f(name_byte);
    cls.lead      = lead_f(name_byte);
    cls.trail     = trail_f(name_byte);
  end

endmodule

// ===== src/sfn_tracker.sv =====
// ----------------------------------------------------------------------------
// sfn_tracker: name state and result register
// Tracks the trail phase, sticky error and length, and registers the verdict.
// ----------------------------------------------------------------------------
module sfn_tracker #(
  parameter int MAX_NAME_LEN = sfn_pkg::MaxNameLenDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,      // one byte leaves the input register
  input  sfn_pkg::byte_class_t cls,
  input  logic                 res_take,  // downstream takes the result beat
  output logic                 res_valid,
  output logic                 res_ok
);
  import sfn_pkg::*;

  localparam logic [CountW-1:0] CountMax = CountW'(MAX_NAME_LEN);
  localparam logic [CountW-1:0] CountSat = CountW'(MAX_NAME_LEN + 1);

  logic              expect_trail, expect_trail_next;
  logic              error_seen, error_seen_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic              verdict;

  // Verdict for a terminator arriving in the current state.
  assign verdict = !error_seen && !expect_trail &&
                   (byte_count != '0) && (byte_count <= CountMax);

  // Next state: a terminator clears the name state, any other byte advances it.
  always_comb begin
    expect_trail_next = expect_trail;
    error_seen_next   = error_seen;
    byte_count_next   = byte_count;
    if (cls.is_end) begin
      expect_trail_next = 1'b0;
      error_seen_next   = 1'b0;
      byte_count_next   = '0;
    end else begin
      if (byte_count < CountSat) begin
        byte_count_next = byte_count + 1'b1;
      end
      if (expect_trail) begin
        expect_trail_next = 1'b0;
        if (!cls.trail) begin
          error_seen_next = 1'b1;
        end
      end else if (cls.single_ok) begin
        expect_trail_next = 1'b0;
      end else if (cls.lead) begin
        expect_trail_next = 1'b1;
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  // Name state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_trail <= 1'b0;
      error_seen   <= 1'b0;
      byte_count   <= '0;
    end else if (step) begin
      expect_trail <= expect_trail_next;
      error_seen   <= error_seen_next;
      byte_count   <= byte_count_next;
    end
  end

  // Result register: loaded by a terminator, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && cls.is_end) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cls.is_end) begin
      res_ok <= verdict;
    end
  end

  // The length counter never passes its saturation point.
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountSat)
    else $error("byte_count above saturation");

  // A terminator clears all name state.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    step && cls.is_end |=> (byte_count == '0) && !expect_trail && !error_seen)
    else $error("state not cleared after terminator");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |-> !(step && cls.is_end))
    else $error("result overwritten while pending");

  // A sticky error always yields a rejection.
  a_err_reject: assert property (@(posedge clk) disable iff (rst)
    step && cls.is_end && error_seen |=> res_valid && !res_ok)
    else $error("error not reported as rejection");

endmodule

// ===== src/sjis_file_name_checker_core.sv =====
// ----------------------------------------------------------------------------
// sjis_file_name_checker_core: Shift-JIS file name checker
// Checks a byte stream of file names and gives one verdict per name.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one name byte per beat; a zero byte ends the
//   name. Each terminator produces one beat on the master stream whose bit 0
//   is 1 for a valid name and 0 for a rejected one. Other bytes produce no
//   output beat.
//   A terminator passes the input register and then the result register
//   before its verdict shows on the master side; it waits in the input
//   register while the result register is full and not taken. Throughput:
//   one byte per cycle, except while a terminator waits in that way.
//   Reset (rst, synchronous, active high) empties both registers and clears
//   the name state, so the next byte starts a fresh name.
//   When the receiver stalls, the pending verdict is held; name bytes keep
//   flowing until a second terminator reaches the input register, which
//   then waits and backpressures the slave side.
// ----------------------------------------------------------------------------
module sjis_file_name_checker_core #(
  parameter int MAX_NAME_LEN = sfn_pkg::MaxNameLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] name_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] name_ok, [7:1] zero
);
  import sfn_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        step;
  logic        res_ok;
  byte_class_t cls;

  // Byte decode of the registered input.
  sfn_classify u_classify (
    .name_byte (in_byte),
    .cls       (cls)
  );

  // A byte moves on unless it is a terminator facing a full result register.
  assign step = in_valid &&
                (!cls.is_end || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Name state and verdict register.
  sfn_tracker #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cls       (cls),
    .res_take  (m_axis_tready),
    .res_valid (m_axis_tvalid),
    .res_ok    (res_ok)
  );

  assign m_axis_tdata = {7'b0, res_ok};

endmodule
